/* rtl/core/rcm_pkg.sv */
// ---------------------------------------------------------------------------
// Radix conversion package
// Shared constants, types and helper functions for the radix conversion core.
// ---------------------------------------------------------------------------
package rcm_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int MAX_DIGITS_DEF = 32;

  localparam int RADIX_W = 5;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [DIGIT_W-1:0] LETTER_THRESHOLD = 4'd10;
  localparam logic [CHAR_W-1:0]  CHAR_DIGIT_BASE  = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_LETTER_BASE = 7'd55;

  // One digit handed from the divider to the digit stack.
  typedef struct packed {
    logic               valid;
    logic [DIGIT_W-1:0] digit;
    logic               done;
  } push_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] b;
    b = r;
    if (r < RADIX_MIN) begin
      b = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      b = RADIX_MAX;
    end
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] char_of_digit(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d >= LETTER_THRESHOLD) begin
      c = CHAR_LETTER_BASE + CHAR_W'(d);
    end else begin
      c = CHAR_DIGIT_BASE + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

/* rtl/core/rcm_if.sv */
// ---------------------------------------------------------------------------
// Radix conversion channel interfaces
// Valid/ready channels for input items and for result digits.
// ---------------------------------------------------------------------------
interface item_if import rcm_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [RADIX_W-1:0]    radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

interface result_if import rcm_pkg::*;;
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit;
  logic [CHAR_W-1:0]  digit_char;
  logic               last;

  modport source (output valid, output digit, output digit_char, output last, input ready);
  modport sink   (input valid, input digit, input digit_char, input last, output ready);
endinterface

/* rtl/core/rcm_divider.sv */
// ---------------------------------------------------------------------------
// Radix conversion divider
// Bit-serial restoring divider that peels off one remainder digit per pass.
// ---------------------------------------------------------------------------
module rcm_divider import rcm_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [RADIX_W-1:0]    radix,
  output logic                  busy,
  output push_t                 push
);

  localparam int CNT_W = $clog2(VALUE_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

  logic                  shifting;
  logic [VALUE_BITS-1:0] quo;
  logic [DIGIT_W-1:0]    rem;
  logic [RADIX_W-1:0]    base;
  logic [CNT_W-1:0]      cnt;

  logic [RADIX_W-1:0] partial;
  logic [RADIX_W-1:0] partial_diff;
  logic               ge;
  logic [DIGIT_W-1:0] rem_next;
  logic               quo_ge_base;
  logic               finish;

  // One quotient bit per cycle: shift the next dividend bit into the partial
  // remainder and subtract the base when it fits.
  assign partial      = {rem, quo[VALUE_BITS-1]};
  assign ge           = (partial >= base);
  assign partial_diff = partial - base;
  assign rem_next     = ge ? partial_diff[DIGIT_W-1:0] : partial[DIGIT_W-1:0];

  assign quo_ge_base = (|quo[VALUE_BITS-1:RADIX_W]) || (quo[RADIX_W-1:0] >= base);
  assign finish      = busy && !shifting && !quo_ge_base;

  assign push.valid = finish || (busy && shifting && (cnt == CNT_LAST));
  assign push.digit = shifting ? rem_next : quo[DIGIT_W-1:0];
  assign push.done  = finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      shifting <= 1'b0;
    end else if (!busy) begin
      if (start) begin
        busy     <= 1'b1;
        shifting <= 1'b0;
      end
    end else if (!shifting) begin
      if (quo_ge_base) begin
        shifting <= 1'b1;
      end else begin
        busy <= 1'b0;
      end
    end else if (cnt == CNT_LAST) begin
      shifting <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy) begin
      quo  <= value;
      base <= clamp_radix(radix);
    end else if (!shifting) begin
      rem <= '0;
      cnt <= '0;
    end else begin
      quo <= {quo[VALUE_BITS-2:0], ge};
      rem <= rem_next;
      cnt <= cnt + 1'b1;
    end
  end

endmodule

/* rtl/core/rcm_stack.sv */
// ---------------------------------------------------------------------------
// Radix conversion digit stack
// Collects digits least significant first and pops them into the output.
// ---------------------------------------------------------------------------
module rcm_stack import rcm_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  push_t              push,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DIGIT_W-1:0] out_digit,
  output logic [CHAR_W-1:0]  out_char,
  output logic               out_last
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int AW    = $clog2(MAX_DIGITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]         state;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_dec;
  logic               wr_en;
  logic [DIGIT_W-1:0] mem [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_data;

  assign count_dec = count - 1'b1;
  assign wr_en     = push.valid && (count < CNT_W'(MAX_DIGITS));
  assign busy      = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[AW-1:0]] <= push.digit;
    end
    rd_data <= mem[count_dec[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (wr_en) begin
            count <= count + 1'b1;
          end
          if (push.done) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          count <= count_dec;
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          out_valid <= 1'b1;
          state     <= ST_HOLD;
        end
        ST_HOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= out_last ? ST_IDLE : ST_READ;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      out_digit <= rd_data;
      out_char  <= char_of_digit(rd_data);
      out_last  <= (count == '0);
    end
  end

endmodule

/* rtl/core/radix_conversion_msd_first_top.sv */
// Sequence: the bit-serial divider (one quotient bit per cycle) runs one pass
// per remainder digit, then the stack pops each digit via read, load, hold.
// Throughput: one item at a time; the next item is taken once the last digit
// of the previous one has been transferred.
// Reset: synchronous, active-high rst clears the control state; the digit
// stack memory itself is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
// Radix conversion, most significant digit first
// Converts an unsigned integer into base 2..16 digits with ASCII characters.
// ---------------------------------------------------------------------------
module radix_conversion_msd_first_top import rcm_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input logic    clk,
  input logic    rst,
  item_if.sink   item,
  result_if.source result
);

  // The divider repeatedly divides the held value by the clamped base. Each
  // pass produces one remainder, which is pushed onto the digit stack; when
  // the quotient drops below the base it is pushed as the final, most
  // significant digit and the divider signals it is done.
  logic  div_busy;
  logic  stk_busy;
  push_t push;
  logic  start;

  // An item is taken only when both the divider and the stack are idle, so a
  // new transfer never overlaps the digits of the previous item.
  assign item.ready = !div_busy && !stk_busy;
  assign start      = item.valid && item.ready;

  rcm_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .value (item.value),
    .radix (item.radix),
    .busy  (div_busy),
    .push  (push)
  );

  // The stack pops the digits back out most significant first, one registered
  // memory read per digit, and holds each result until it is transferred.
  rcm_stack #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .busy      (stk_busy),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_digit (result.digit),
    .out_char  (result.digit_char),
    .out_last  (result.last)
  );

endmodule

/* rtl/core/rcm_checker.sv */
// ---------------------------------------------------------------------------
// Radix conversion port checker
// Concurrent assertions on the top-level ports, attached by bind.
// ---------------------------------------------------------------------------
module rcm_checker import rcm_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input logic               result_valid,
  input logic               result_ready,
  input logic [DIGIT_W-1:0] digit,
  input logic [CHAR_W-1:0]  digit_char,
  input logic               last
);

  // A result waits until it is transferred.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result valid dropped before transfer");

  // Inputs are never taken while digits are still being delivered.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && result_valid))
    else $error("input ready while a result is pending");

  // Input ready is low right after an item is taken.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("input ready right after a transfer");

  // Input ready stays low right after a transfer that is not the last digit.
  a_more_digits: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !last |=> !item_ready)
    else $error("input ready before the last digit");

  // The character of a valid result always matches its digit.
  a_char_match: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> digit_char == char_of_digit(digit))
    else $error("digit character mismatch");

endmodule

bind radix_conversion_msd_first_top rcm_checker u_rcm_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .digit        (result.digit),
  .digit_char   (result.digit_char),
  .last         (result.last)
);
